[rtl/rmt_pkg.sv]
// Shared constants, codes and transfer types for the range-minimum tree.
package rmt_pkg;

    // Default number of table entries.
    localparam int DEPTH_DEF = 1024;

    // Fixed field widths of the stream items and the count register.
    localparam int IDX_W = 10;
    localparam int VAL_W = 32;
    localparam int CNT_W = 11;

    // Entry count after reset.
    localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

    // Command codes carried with each input item.
    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    // One decoded input item.
    typedef struct packed {
        t_cmd                    cmd;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        range_low;
        logic [IDX_W-1:0]        range_high;
    } t_req;

    // One query result.
    typedef struct packed {
        logic                    found;
        logic [IDX_W-1:0]        min_index;
        logic signed [VAL_W-1:0] min_value;
    } t_res;

endpackage

[rtl/rmt_cmp.sv]
// Shared compare unit: picks the smaller value, the lower index on a tie.
module rmt_cmp #(
    parameter int IW = 10
) (
    input  logic [IW-1:0]                    i_a_idx,
    input  logic signed [rmt_pkg::VAL_W-1:0] i_a_val,
    input  logic [IW-1:0]                    i_b_idx,
    input  logic signed [rmt_pkg::VAL_W-1:0] i_b_val,
    output logic [IW-1:0]                    o_idx,
    output logic signed [rmt_pkg::VAL_W-1:0] o_val
);
    import rmt_pkg::*;

    logic b_wins;

    // The second operand wins only when it is strictly better.
    assign b_wins = (i_b_val < i_a_val) || ((i_b_val == i_a_val) && (i_b_idx < i_a_idx));
    assign o_idx  = b_wins ? i_b_idx : i_a_idx;
    assign o_val  = b_wins ? i_b_val : i_a_val;

endmodule

[rtl/rmt_mem.sv]
// Tree node memory: one write port, one read port with registered read data.
module rmt_mem #(
    parameter int WORDS = 2048,
    parameter int DW    = 42,
    localparam int AW   = $clog2(WORDS)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    import rmt_pkg::*;

    logic [DW-1:0] r_mem [WORDS];
    logic [DW-1:0] r_rdata;

    // Node write.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Node read, data valid in the following cycle.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/rmt_seq.sv]
// Sequencer that walks the tree for writes and queries through one memory port.
module rmt_seq #(
    parameter int DEPTH = rmt_pkg::DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [rmt_pkg::CNT_W-1:0] i_count,
    input  logic                      i_req_valid,
    input  rmt_pkg::t_req             i_req,
    output logic                      o_req_ready,
    output logic                      o_res_valid,
    output rmt_pkg::t_res             o_res,
    input  logic                      i_res_ready
);
    import rmt_pkg::*;

    // Entry index, node address and range bound widths.
    localparam int IW = $clog2(DEPTH);
    localparam int NW = IW + 1;
    localparam int LW = NW + 1;
    localparam int DW = IW + VAL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLIMB,
        S_QLEFT,
        S_QRIGHT,
        S_DONE
    } t_state;

    t_state                  r_state, n_state;
    logic [LW-1:0]           r_l, n_l;
    logic [LW-1:0]           r_r, n_r;
    logic [NW-1:0]           r_node, n_node;
    logic [IW-1:0]           r_best_idx, n_best_idx;
    logic signed [VAL_W-1:0] r_best_val, n_best_val;
    logic                    r_have, n_have;
    logic                    r_pend, n_pend;

    logic                    mem_we;
    logic [NW-1:0]           mem_waddr;
    logic [DW-1:0]           mem_wdata;
    logic                    mem_re;
    logic [NW-1:0]           mem_raddr;
    logic [DW-1:0]           mem_rdata;

    logic [IW-1:0]           rd_idx;
    logic signed [VAL_W-1:0] rd_val;
    logic [IW-1:0]           pick_idx;
    logic signed [VAL_W-1:0] pick_val;

    logic                    idx_ok;
    logic                    q_empty;
    logic [CNT_W-1:0]        hi_clamp;
    logic [LW-1:0]           leaf;
    logic [LW-1:0]           l_start;
    logic [LW-1:0]           r_start;
    logic [NW-1:0]           parent;
    logic [LW-1:0]           r_dec;

    // Node memory holds the winning index and its value for every node.
    rmt_mem #(
        .WORDS (2 * DEPTH),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_idx = mem_rdata[IW-1:0];
    assign rd_val = mem_rdata[DW-1:IW];

    // One compare unit serves both the path refresh and the query fold.
    rmt_cmp #(
        .IW (IW)
    ) u_cmp (
        .i_a_idx (r_best_idx),
        .i_a_val (r_best_val),
        .i_b_idx (rd_idx),
        .i_b_val (rd_val),
        .o_idx   (pick_idx),
        .o_val   (pick_val)
    );

    // Request decode: range checks and starting node numbers.
    assign idx_ok   = {1'b0, i_req.index} < i_count;
    assign q_empty  = (i_count == '0) || (i_req.range_low > i_req.range_high) ||
                      ({1'b0, i_req.range_low} >= i_count);
    assign hi_clamp = ({1'b0, i_req.range_high} >= i_count) ? (i_count - CNT_W'(1)) :
                      {1'b0, i_req.range_high};
    assign leaf     = LW'(i_req.index) + LW'(DEPTH);
    assign l_start  = LW'(i_req.range_low) + LW'(DEPTH);
    assign r_start  = LW'(hi_clamp) + LW'(DEPTH) + LW'(1);
    assign parent   = r_node >> 1;
    assign r_dec    = r_r - LW'(1);

    // Next-state and memory control.
    always_comb begin
        n_state    = r_state;
        n_l        = r_l;
        n_r        = r_r;
        n_node     = r_node;
        n_best_idx = r_best_idx;
        n_best_val = r_best_val;
        n_have     = r_have;
        n_pend     = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;

        // Fold a node read in the previous cycle into the running minimum.
        if (r_pend) begin
            n_best_idx = r_have ? pick_idx : rd_idx;
            n_best_val = r_have ? pick_val : rd_val;
            n_have     = 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_req.cmd == CMD_WRITE) begin
                        if (idx_ok) begin
                            mem_we     = 1'b1;
                            mem_waddr  = leaf[NW-1:0];
                            mem_wdata  = {i_req.value, IW'(i_req.index)};
                            n_best_idx = IW'(i_req.index);
                            n_best_val = i_req.value;
                            n_node     = leaf[NW-1:0];
                            mem_re     = 1'b1;
                            mem_raddr  = {leaf[NW-1:1], ~leaf[0]};
                            n_state    = S_CLIMB;
                        end
                    end else begin
                        n_have = 1'b0;
                        if (q_empty) begin
                            n_state = S_DONE;
                        end else begin
                            n_l     = l_start;
                            n_r     = r_start;
                            n_state = S_QLEFT;
                        end
                    end
                end
            end
            S_CLIMB: begin
                // Sibling data is here: write the parent and read its sibling.
                mem_we     = 1'b1;
                mem_waddr  = parent;
                mem_wdata  = {pick_val, pick_idx};
                n_best_idx = pick_idx;
                n_best_val = pick_val;
                n_node     = parent;
                if (parent == NW'(1)) begin
                    n_state = S_IDLE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = {parent[NW-1:1], ~parent[0]};
                end
            end
            S_QLEFT: begin
                if (r_l >= r_r) begin
                    n_state = S_DONE;
                end else begin
                    if (r_l[0]) begin
                        mem_re    = 1'b1;
                        mem_raddr = r_l[NW-1:0];
                        n_pend    = 1'b1;
                        n_l       = r_l + LW'(1);
                    end
                    n_state = S_QRIGHT;
                end
            end
            S_QRIGHT: begin
                if (r_r[0]) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_dec[NW-1:0];
                    n_pend    = 1'b1;
                end
                n_l     = r_l >> 1;
                n_r     = r_r >> 1;
                n_state = S_QLEFT;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_have  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_have  <= n_have;
            r_pend  <= n_pend;
        end
        r_l        <= n_l;
        r_r        <= n_r;
        r_node     <= n_node;
        r_best_idx <= n_best_idx;
        r_best_val <= n_best_val;
    end

    assign o_req_ready     = (r_state == S_IDLE);
    assign o_res_valid     = (r_state == S_DONE);
    assign o_res.found     = r_have;
    assign o_res.min_index = r_have ? IDX_W'(r_best_idx) : '0;
    assign o_res.min_value = r_have ? r_best_val : '0;

`ifndef SYNTHESIS
    // The query window never inverts while the walk is running.
    a_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_QLEFT) || (r_state == S_QRIGHT)) |-> (r_l <= r_r))
        else $error("query window inverted");

    // A node read for the fold is only outstanding during the query walk.
    a_pend_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ((r_state == S_QLEFT) || (r_state == S_QRIGHT)))
        else $error("node read outstanding outside the query walk");

    // The climb stops once the root has been written.
    a_climb_below_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLIMB) |-> (r_node > NW'(1)))
        else $error("climb continued past the root");

    // A completed query walk always has a minimum.
    a_walk_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_QLEFT) && (n_state == S_DONE)) |=> r_have)
        else $error("query walk ended without a minimum");
`endif

endmodule

[rtl/range_min_index_tree_core.sv]
// Top level of the range-minimum tree: stream ports, count register, output stage.
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+----------------------------------
//  s stream | in        | i_s_tvalid / o_s_tready   | i_s_tdata, i_s_tuser (command)
//  m stream | out       | o_m_tvalid / i_m_tready   | o_m_tdata, o_m_tuser (found)
//  cfg      | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (entry count)
//
// A write climbs one tree level per cycle after the leaf write.
// A query takes a left step and a right step per tree level (S_QLEFT, S_QRIGHT),
// set by the single read port of the node memory; an empty range goes straight to the result.
// Reset is synchronous and active low; the node memory is not cleared.
// A new item may be taken while the previous result waits in the output register.
module range_min_index_tree_core #(
    parameter int DEPTH = rmt_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [9:0] index, [41:10] value, [51:42] range_low, [61:52] range_high, [63:62] zero
    input  logic [63:0] i_s_tdata,
    // [0] command
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [9:0] min_index, [41:10] min_value, [47:42] zero
    output logic [47:0] o_m_tdata,
    // [0] found
    output logic        o_m_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data
);
    import rmt_pkg::*;

    localparam int CapCount = (DEPTH < 2047) ? DEPTH : 2047;

    logic [CNT_W-1:0] r_entry_count;
    logic [CNT_W-1:0] count;
    t_req             req;
    logic             req_ready;
    logic             res_valid;
    t_res             res;
    logic             res_take;
    logic             r_m_valid;
    t_res             r_m_res;

    // Entry count register, always ready; the count is sampled when an item is accepted.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_entry_count <= i_cfg_data;
        end
    end

    // Entries in use cannot exceed the table.
    assign count = (r_entry_count > CNT_W'(CapCount)) ? CNT_W'(CapCount) : r_entry_count;

    // Input unpacking.
    assign req.cmd        = t_cmd'(i_s_tuser);
    assign req.index      = i_s_tdata[9:0];
    assign req.value      = i_s_tdata[41:10];
    assign req.range_low  = i_s_tdata[51:42];
    assign req.range_high = i_s_tdata[61:52];

    rmt_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_count     (count),
        .i_req_valid (i_s_tvalid),
        .i_req       (req),
        .o_req_ready (req_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_take)
    );

    assign o_s_tready = req_ready;

    // Output register: loads when empty or when its transfer completes.
    assign res_take = res_valid && (!r_m_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_take) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
        if (res_take) begin
            r_m_res <= res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {6'b0, r_m_res.min_value, r_m_res.min_index};
    assign o_m_tuser  = r_m_res.found;

`ifndef SYNTHESIS
    // A result without a minimum carries zero index and value.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("empty result carries data");
`endif

endmodule

[test/tb.sv]
// Self-checking testbench for the range-minimum index tree core.
`timescale 1ns / 1ps

module tb;
    import rmt_pkg::*;

    localparam int TABLE_SIZE = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1250;
    // Settle time after the drain, long enough to cover any tail of work.
    localparam int SETTLE_CYCLES = 40;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;
    logic        o_m_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data = '0;

    // Shadow copy of the table and the entry count register.
    logic signed [VAL_W-1:0] table_values [TABLE_SIZE];
    bit                      table_written [TABLE_SIZE];
    logic [CNT_W-1:0]        entry_count_reg = COUNT_RESET;

    t_res answers_due [$];
    int   mismatch_count = 0;
    int   item_total = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    range_min_index_tree_core #(
        .DEPTH(TABLE_SIZE)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Entries in use; an oversized count saturates at the table size.
    function automatic int used_entries();
        return (entry_count_reg > TABLE_SIZE) ? TABLE_SIZE : int'(entry_count_reg);
    endfunction

    // Minimum over an inclusive range, lowest index first on equal values.
    function automatic t_res range_minimum(int first, int last);
        t_res answer;
        int   n;
        answer = '0;
        n = used_entries();
        if (n == 0 || first > last || first >= n) begin
            return answer;
        end
        if (last >= n) begin
            last = n - 1;
        end
        answer.found = 1'b1;
        answer.min_index = first[IDX_W-1:0];
        answer.min_value = table_values[first];
        for (int k = first + 1; k <= last; k++) begin
            if (table_values[k] < answer.min_value) begin
                answer.min_index = k[IDX_W-1:0];
                answer.min_value = table_values[k];
            end
        end
        return answer;
    endfunction

    // Update the shadow table or queue the expected answer for one accepted item.
    function automatic void apply_item(t_req item);
        if (item.cmd == CMD_WRITE) begin
            if (int'(item.index) < used_entries()) begin
                table_values[item.index] = item.value;
                table_written[item.index] = 1'b1;
                item_total++;
            end
        end else begin
            answers_due.push_back(range_minimum(item.range_low, item.range_high));
            item_total++;
        end
    endfunction

    function automatic t_req write_item(int idx, logic signed [VAL_W-1:0] val);
        t_req item;
        item.cmd = CMD_WRITE;
        item.index = idx[IDX_W-1:0];
        item.value = val;
        item.range_low = IDX_W'($urandom);
        item.range_high = IDX_W'($urandom);
        return item;
    endfunction

    function automatic t_req query_item(int first, int last);
        t_req item;
        item.cmd = CMD_QUERY;
        item.index = IDX_W'($urandom);
        item.value = $urandom;
        item.range_low = first[IDX_W-1:0];
        item.range_high = last[IDX_W-1:0];
        return item;
    endfunction

    // Small values give many ties; the extremes show up often.
    function automatic logic signed [VAL_W-1:0] random_value();
        logic signed [VAL_W-1:0] val;
        case ($urandom_range(0, 3))
            0: val = $urandom_range(0, 7) - 4;
            1: val = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
            default: val = $urandom;
        endcase
        return val;
    endfunction

    // A query that never touches an unwritten entry in use.
    function automatic t_req random_query(int n, int win_lo, int win_hi);
        int first;
        int last;
        int run_end;
        if (n == 0 || $urandom_range(0, 99) < 15) begin
            if (n < TABLE_SIZE && $urandom_range(0, 1) == 1) begin
                first = $urandom_range(n, TABLE_SIZE - 1);
                last = $urandom_range(0, TABLE_SIZE - 1);
            end else begin
                first = $urandom_range(1, TABLE_SIZE - 1);
                last = $urandom_range(0, first - 1);
            end
            return query_item(first, last);
        end
        first = $urandom_range(win_lo, win_hi);
        run_end = first;
        while (run_end + 1 < n && table_written[run_end + 1]) begin
            run_end++;
        end
        if (run_end == n - 1 && $urandom_range(0, 3) == 0) begin
            last = $urandom_range(0, 1) ? TABLE_SIZE - 1 : $urandom_range(n - 1, TABLE_SIZE - 1);
        end else begin
            last = $urandom_range(first, run_end);
        end
        return query_item(first, last);
    endfunction

    // Send one item, with random idle cycles before it, and wait for its transfer.
    task automatic send_item(input t_req item);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {2'b00, item.range_high, item.range_low, item.value, item.index};
        i_s_tuser <= item.cmd;
        do @(posedge i_clk); while (!o_s_tready);
        apply_item(item);
    endtask

    // Drain the block, then write the entry count register.
    task automatic set_entry_count(input logic [CNT_W-1:0] count);
        i_s_tvalid <= 1'b0;
        while (answers_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= count;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        entry_count_reg = count;
    endtask

    // The full table is in use after reset: touch both ends of it.
    task automatic test_reset_count();
        send_item(write_item(TABLE_SIZE - 1, VAL_MAX));
        send_item(write_item(0, VAL_MIN));
        send_item(query_item(TABLE_SIZE - 1, TABLE_SIZE - 1));
        send_item(query_item(0, 0));
        send_item(query_item(5, 3));
    endtask

    // A small table with extreme values and ties, clamped and empty ranges.
    task automatic test_small_table();
        logic signed [VAL_W-1:0] fill [8];
        fill = '{32'sd5, -32'sd3, VAL_MIN, 32'sd7, VAL_MIN, VAL_MAX, -32'sd3, 32'sd0};
        set_entry_count(11'd8);
        for (int k = 0; k < 8; k++) begin
            send_item(write_item(k, fill[k]));
        end
        // This write lies beyond the entries in use and must be dropped.
        send_item(write_item(9, VAL_MIN));
        send_item(query_item(0, TABLE_SIZE - 1));
        send_item(query_item(3, 7));
        send_item(query_item(0, 1));
        send_item(query_item(5, 5));
        send_item(query_item(8, 8));
        send_item(query_item(6, TABLE_SIZE - 1));
    endtask

    // A zero count, an oversized count that saturates, and a single entry.
    task automatic test_count_extremes();
        set_entry_count(11'd0);
        send_item(write_item(0, VAL_MIN));
        send_item(query_item(0, 0));
        set_entry_count(11'd2047);
        send_item(query_item(TABLE_SIZE - 1, TABLE_SIZE - 1));
        set_entry_count(11'd1);
        send_item(query_item(0, TABLE_SIZE - 1));
    endtask

    // Phases of random traffic over random table sizes and idle patterns.
    task automatic test_random_traffic();
        int               target;
        int               phase;
        int               n;
        int               win_lo;
        int               win_hi;
        int               len;
        int               idx;
        int               pick;
        logic [CNT_W-1:0] count;
        target = item_total + RANDOM_ITEMS;
        phase = 0;
        win_lo = 0;
        win_hi = 0;
        while (item_total < target) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                case ($urandom_range(0, 3))
                    0: count = 11'd0;
                    1: count = 11'd1;
                    2: count = 11'd1024;
                    default: count = 11'd2047;
                endcase
            end else if (pick < 7) begin
                count = CNT_W'($urandom_range(2, 64));
            end else begin
                count = CNT_W'($urandom_range(65, 1024));
            end
            set_entry_count(count);
            n = used_entries();

            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase

            // Fill a window of entries so that queries have written data to cover.
            if (n > 0) begin
                len = $urandom_range(1, (n < 40) ? n : 40);
                win_lo = ($urandom_range(0, 2) == 0) ? n - len : $urandom_range(0, n - len);
                win_hi = win_lo + len - 1;
                for (int k = win_lo; k <= win_hi; k++) begin
                    send_item(write_item(k, random_value()));
                end
            end

            repeat (60) begin
                if (n == 0 || $urandom_range(0, 99) < 55) begin
                    send_item(random_query(n, win_lo, win_hi));
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 15 && n < TABLE_SIZE) begin
                        idx = $urandom_range(n, TABLE_SIZE - 1);
                    end else if (pick < 55) begin
                        idx = $urandom_range(win_lo, (win_hi + 8 < n) ? win_hi + 8 : n - 1);
                    end else begin
                        idx = $urandom_range(0, n - 1);
                    end
                    send_item(write_item(idx, random_value()));
                end
            end
            phase++;
        end
    endtask

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare each result transfer with the oldest expected answer.
    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result found=%0d index=%0d value=%0d", $realtime,
                         o_m_tuser, o_m_tdata[9:0], $signed(o_m_tdata[41:10]));
                mismatch_count++;
            end else begin
                want = answers_due.pop_front();
                if (o_m_tuser !== want.found) begin
                    $display("%0t: found expected %0d actual %0d", $realtime,
                             want.found, o_m_tuser);
                    mismatch_count++;
                end
                if (o_m_tdata[9:0] !== want.min_index) begin
                    $display("%0t: min_index expected %0d actual %0d", $realtime,
                             want.min_index, o_m_tdata[9:0]);
                    mismatch_count++;
                end
                if (o_m_tdata[41:10] !== want.min_value) begin
                    $display("%0t: min_value expected %0d actual %0d", $realtime,
                             want.min_value, $signed(o_m_tdata[41:10]));
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_count();
        test_small_table();
        test_count_extremes();
        test_random_traffic();

        // Let the last transfers drain before the verdict.
        i_s_tvalid <= 1'b0;
        while (answers_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && answers_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(5_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
rtl/rmt_pkg.sv
rtl/rmt_cmp.sv
rtl/rmt_mem.sv
rtl/rmt_seq.sv
rtl/range_min_index_tree_core.sv
test/tb.sv
